>>> hw/rtl/nrfg_pkg.sv
`default_nettype none

package nrfg_pkg;

   localparam int MAX_RUNS_DEFAULT    = 64;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Run counters cover the whole legal range of MAX_RUNS (1 to 64)
   localparam int RUN_CNT_W = 7;
   localparam int DIM_W     = 20;
   localparam int UNIT_W    = 7;
   localparam int BYTE_W    = 64;
   localparam int CHUNK_W   = 32;
   localparam int PROD_W    = DIM_W + CHUNK_W;

   typedef enum logic [1:0] {
      ERR_NONE          = 2'd0,
      ERR_RANK_MISMATCH = 2'd1,
      ERR_TOO_MANY      = 2'd2,
      ERR_BAD_RANK      = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      CLS_ERR,
      CLS_EMPTY,
      CLS_SINGLE,
      CLS_LOOP,
      CLS_GRID
   } class_type;

   // Setup steps: each is a 20 x 64 multiply-accumulate done in two 32-bit halves
   typedef enum logic [2:0] {
      OP_ROW,
      OP_PLANE,
      OP_BASE,
      OP_MID,
      OP_INNER,
      OP_LEN
   } op_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_ADD,
      F_PUSH
   } front_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    base;
      logic [BYTE_W-1:0]    len;
      logic [BYTE_W-1:0]    stride_outer;
      logic [BYTE_W-1:0]    stride_mid;
      logic [RUN_CNT_W-1:0] n_outer;
      logic [RUN_CNT_W-1:0] n_mid;
      logic                 wr;
      err_type              err;
   } run_desc_type;

endpackage

`default_nettype wire

>>> hw/rtl/nrfg_front.sv
`default_nettype none

module nrfg_front #(
   parameter int MAX_RUNS = nrfg_pkg::MAX_RUNS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_object_rank,
   input  wire logic [1:0]                    req_region_rank,
   input  wire logic [nrfg_pkg::UNIT_W-1:0]   req_elem_bytes,
   input  wire logic [nrfg_pkg::DIM_W-1:0]    req_dim_mid,
   input  wire logic [nrfg_pkg::DIM_W-1:0]    req_dim_inner,
   input  wire logic [nrfg_pkg::DIM_W-1:0]    req_start_outer,
   input  wire logic [nrfg_pkg::DIM_W-1:0]    req_start_mid,
   input  wire logic [nrfg_pkg::DIM_W-1:0]    req_start_inner,
   input  wire logic [nrfg_pkg::DIM_W-1:0]    req_count_outer,
   input  wire logic [nrfg_pkg::DIM_W-1:0]    req_count_mid,
   input  wire logic [nrfg_pkg::DIM_W-1:0]    req_count_inner,
   input  wire logic                          req_write_dir,
   output logic                               push_valid,
   input  wire logic                          push_ready,
   output nrfg_pkg::run_desc_type             push_data
);

   localparam int DW = nrfg_pkg::DIM_W;
   localparam int BW = nrfg_pkg::BYTE_W;
   localparam int CW = nrfg_pkg::CHUNK_W;
   localparam int PW = nrfg_pkg::PROD_W;
   localparam int RW = nrfg_pkg::RUN_CNT_W;

   nrfg_pkg::front_state_type state_ff, state_in;
   nrfg_pkg::op_type          op_ff, op_in;
   logic                      half_ff, half_in;

   logic [1:0]               orank_ff, rrank_ff;
   logic [nrfg_pkg::UNIT_W-1:0] unit_ff;
   logic [DW-1:0]            dm_ff, di_ff, so_ff, sm_ff, si_ff, co_ff, cm_ff, ci_ff;
   logic                     wr_ff;

   logic [PW-1:0]            prod_ff;
   logic [BW-1:0]            row_ff, plane_ff, base_ff, len_ff;

   logic                     accept;
   nrfg_pkg::class_type      cls;
   nrfg_pkg::err_type        cls_err;
   logic [2*RW-1:0]          grid_runs;
   logic [BW-1:0]            unit64;
   logic [DW-1:0]            mul_a;
   logic [BW-1:0]            mul_b;
   logic [CW-1:0]            mul_chunk;
   logic [BW-1:0]            addend, acc_old, acc_new;
   logic                     acc_clear;

   assign accept = req_valid && req_ready;
   assign unit64 = BW'(unit_ff);

   // Classify the held request
   assign grid_runs = (2*RW)'(co_ff[RW-1:0]) * (2*RW)'(cm_ff[RW-1:0]);

   always_comb begin
      cls     = nrfg_pkg::CLS_ERR;
      cls_err = nrfg_pkg::ERR_NONE;
      if (orank_ff != rrank_ff) begin
         cls_err = nrfg_pkg::ERR_RANK_MISMATCH;
      end else if (rrank_ff == 2'd0) begin
         cls_err = nrfg_pkg::ERR_BAD_RANK;
      end else if (rrank_ff == 2'd1) begin
         cls = nrfg_pkg::CLS_SINGLE;
      end else if (sm_ff == '0 && cm_ff == dm_ff &&
                   (rrank_ff == 2'd2 || (si_ff == '0 && ci_ff == di_ff))) begin
         cls = nrfg_pkg::CLS_SINGLE;
      end else if (rrank_ff == 2'd2 || (si_ff == '0 && ci_ff == di_ff)) begin
         if (co_ff > DW'(MAX_RUNS)) begin
            cls_err = nrfg_pkg::ERR_TOO_MANY;
         end else if (co_ff == '0) begin
            cls = nrfg_pkg::CLS_EMPTY;
         end else begin
            cls = nrfg_pkg::CLS_LOOP;
         end
      end else begin
         if (co_ff == '0 || cm_ff == '0) begin
            cls = nrfg_pkg::CLS_EMPTY;
         end else if (co_ff > DW'(MAX_RUNS) || cm_ff > DW'(MAX_RUNS) ||
                      grid_runs > (2*RW)'(MAX_RUNS)) begin
            cls_err = nrfg_pkg::ERR_TOO_MANY;
         end else begin
            cls = nrfg_pkg::CLS_GRID;
         end
      end
   end

   // Operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = unit64;
      unique case (op_ff)
         nrfg_pkg::OP_ROW: begin
            mul_a = (rrank_ff == 2'd3) ? di_ff : DW'(1);
            mul_b = unit64;
         end
         nrfg_pkg::OP_PLANE: begin
            mul_a = (rrank_ff[1]) ? dm_ff : DW'(1);
            mul_b = row_ff;
         end
         nrfg_pkg::OP_BASE: begin
            mul_a = so_ff;
            mul_b = plane_ff;
         end
         nrfg_pkg::OP_MID: begin
            mul_a = (rrank_ff[1]) ? sm_ff : '0;
            mul_b = row_ff;
         end
         nrfg_pkg::OP_INNER: begin
            mul_a = (rrank_ff == 2'd3) ? si_ff : '0;
            mul_b = unit64;
         end
         nrfg_pkg::OP_LEN: begin
            case (cls)
               nrfg_pkg::CLS_SINGLE: begin
                  mul_a = co_ff;
                  mul_b = plane_ff;
               end
               nrfg_pkg::CLS_LOOP: begin
                  mul_a = cm_ff;
                  mul_b = row_ff;
               end
               default: begin
                  mul_a = ci_ff;
                  mul_b = unit64;
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = unit64;
         end
      endcase
      mul_chunk = half_ff ? mul_b[BW-1:CW] : mul_b[CW-1:0];
   end

   // Accumulate step
   always_comb begin
      addend    = half_ff ? {prod_ff[CW-1:0], {CW{1'b0}}} : BW'(prod_ff);
      acc_clear = !half_ff && (op_ff == nrfg_pkg::OP_ROW || op_ff == nrfg_pkg::OP_PLANE ||
                               op_ff == nrfg_pkg::OP_BASE || op_ff == nrfg_pkg::OP_LEN);
      unique case (op_ff)
         nrfg_pkg::OP_ROW:   acc_old = row_ff;
         nrfg_pkg::OP_PLANE: acc_old = plane_ff;
         nrfg_pkg::OP_LEN:   acc_old = len_ff;
         default:            acc_old = base_ff;
      endcase
      acc_new = (acc_clear ? '0 : acc_old) + addend;
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      half_in    = half_ff;
      req_ready  = 1'b0;
      push_valid = 1'b0;
      unique case (state_ff)
         nrfg_pkg::F_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = nrfg_pkg::F_MUL;
               op_in    = nrfg_pkg::OP_ROW;
               half_in  = 1'b0;
            end
         end
         nrfg_pkg::F_MUL: begin
            state_in = nrfg_pkg::F_ADD;
         end
         nrfg_pkg::F_ADD: begin
            state_in = nrfg_pkg::F_MUL;
            half_in  = !half_ff;
            if (half_ff) begin
               unique case (op_ff)
                  nrfg_pkg::OP_ROW:   op_in = nrfg_pkg::OP_PLANE;
                  nrfg_pkg::OP_PLANE: op_in = nrfg_pkg::OP_BASE;
                  nrfg_pkg::OP_BASE:  op_in = nrfg_pkg::OP_MID;
                  nrfg_pkg::OP_MID:   op_in = nrfg_pkg::OP_INNER;
                  nrfg_pkg::OP_INNER: op_in = nrfg_pkg::OP_LEN;
                  default: begin
                     op_in    = nrfg_pkg::OP_ROW;
                     state_in = nrfg_pkg::F_PUSH;
                  end
               endcase
            end
         end
         nrfg_pkg::F_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = nrfg_pkg::F_IDLE;
            end
         end
         default: state_in = nrfg_pkg::F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nrfg_pkg::F_IDLE;
         op_ff    <= nrfg_pkg::OP_ROW;
         half_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         orank_ff <= req_object_rank;
         rrank_ff <= req_region_rank;
         unit_ff  <= req_elem_bytes;
         dm_ff    <= req_dim_mid;
         di_ff    <= req_dim_inner;
         so_ff    <= req_start_outer;
         sm_ff    <= req_start_mid;
         si_ff    <= req_start_inner;
         co_ff    <= req_count_outer;
         cm_ff    <= req_count_mid;
         ci_ff    <= req_count_inner;
         wr_ff    <= req_write_dir;
      end
      if (state_ff == nrfg_pkg::F_MUL) begin
         prod_ff <= PW'(mul_a) * PW'(mul_chunk);
      end
      if (state_ff == nrfg_pkg::F_ADD) begin
         unique case (op_ff)
            nrfg_pkg::OP_ROW:   row_ff   <= acc_new;
            nrfg_pkg::OP_PLANE: plane_ff <= acc_new;
            nrfg_pkg::OP_LEN:   len_ff   <= acc_new;
            default:            base_ff  <= acc_new;
         endcase
      end
   end

   // Descriptor for the run walker
   always_comb begin
      push_data              = '0;
      push_data.wr           = wr_ff;
      push_data.err          = cls_err;
      push_data.stride_outer = plane_ff;
      push_data.stride_mid   = row_ff;
      push_data.n_outer      = RW'(1);
      push_data.n_mid        = RW'(1);
      case (cls)
         nrfg_pkg::CLS_SINGLE: begin
            push_data.base = base_ff;
            push_data.len  = len_ff;
         end
         nrfg_pkg::CLS_LOOP: begin
            push_data.base    = base_ff;
            push_data.len     = len_ff;
            push_data.n_outer = co_ff[RW-1:0];
         end
         nrfg_pkg::CLS_GRID: begin
            push_data.base    = base_ff;
            push_data.len     = len_ff;
            push_data.n_outer = co_ff[RW-1:0];
            push_data.n_mid   = cm_ff[RW-1:0];
         end
         default: begin
            push_data.base = '0;
            push_data.len  = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/nrfg_queue.sv
`default_nettype none

module nrfg_queue #(
   parameter int DEPTH = nrfg_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_valid,
   output logic                        push_ready,
   input  wire nrfg_pkg::run_desc_type push_data,
   output logic                        pop_valid,
   input  wire logic                   pop_ready,
   output nrfg_pkg::run_desc_type      pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   nrfg_pkg::run_desc_type entry_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign push_ready = (cnt_ff != CNT_W'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/nrfg_back.sv
`default_nettype none

module nrfg_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        pop_valid,
   output logic                             pop_ready,
   input  wire nrfg_pkg::run_desc_type      pop_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [nrfg_pkg::BYTE_W-1:0]      rsp_byte_offset,
   output logic [nrfg_pkg::BYTE_W-1:0]      rsp_byte_length,
   output logic                             rsp_run_write,
   output logic [1:0]                       rsp_error_code,
   output logic                             rsp_last_run
);

   localparam int BW = nrfg_pkg::BYTE_W;
   localparam int RW = nrfg_pkg::RUN_CNT_W;

   logic                   act_ff;
   nrfg_pkg::run_desc_type desc_ff;
   logic [BW-1:0]          row_ff, cur_ff;
   logic [RW-1:0]          i_ff, j_ff;

   logic                   out_valid_ff;
   logic [BW-1:0]          out_off_ff, out_len_ff;
   logic                   out_wr_ff, out_last_ff;
   nrfg_pkg::err_type      out_err_ff;

   logic                   slot_free, emit, last_i, last_j, is_last;
   logic [BW-1:0]          next_row;

   assign slot_free = !out_valid_ff || rsp_ready;
   assign emit      = act_ff && slot_free;
   assign pop_ready = !act_ff;
   assign last_i    = (i_ff == desc_ff.n_outer - 1'b1);
   assign last_j    = (j_ff == desc_ff.n_mid - 1'b1);
   assign is_last   = last_i && last_j;
   assign next_row  = row_ff + desc_ff.stride_outer;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!act_ff && pop_valid) begin
            act_ff <= 1'b1;
         end else if (emit && is_last) begin
            act_ff <= 1'b0;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Walk mid index fastest, then step to the next outer row
   always_ff @(posedge clock) begin
      if (!act_ff && pop_valid) begin
         desc_ff <= pop_data;
         row_ff  <= pop_data.base;
         cur_ff  <= pop_data.base;
         i_ff    <= '0;
         j_ff    <= '0;
      end else if (emit) begin
         if (!last_j) begin
            j_ff   <= j_ff + 1'b1;
            cur_ff <= cur_ff + desc_ff.stride_mid;
         end else begin
            j_ff   <= '0;
            i_ff   <= i_ff + 1'b1;
            row_ff <= next_row;
            cur_ff <= next_row;
         end
      end
      if (emit) begin
         out_off_ff  <= cur_ff;
         out_len_ff  <= desc_ff.len;
         out_wr_ff   <= desc_ff.wr;
         out_err_ff  <= desc_ff.err;
         out_last_ff <= is_last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_byte_offset = out_off_ff;
   assign rsp_byte_length = out_len_ff;
   assign rsp_run_write   = out_wr_ff;
   assign rsp_error_code  = out_err_ff;
   assign rsp_last_run    = out_last_ff;

endmodule

`default_nettype wire

>>> hw/rtl/nd_region_file_run_generator_unit.sv
// Region run generator: turns one request for a 1-, 2- or 3-dimensional
// region of a flat row-major object into its contiguous byte runs.
// Input channel req_*: one request per transfer (ranks, element size,
// object extents, region offsets and counts, direction).
// Result channel rsp_*: one run per transfer (byte offset, byte length,
// direction, error code, last marker); the final result of a request
// carries rsp_last_run. Errors and empty regions give a single result.
// Setup: the front end captures a request, forms twelve 20 x 32 partial
// products each followed by an accumulate, then pushes to the queue;
// the run walker then loads the descriptor and registers each run onto rsp_*.
// Throughput: one run per cycle while a request streams out and the
// output register is free to take it (rsp_ready high or register empty).
// The shared multiply-accumulate in the front end and the single run
// walker in the back end set the pace; a descriptor queue between
// them lets setup of the next request overlap the runs of the current one.
// Reset: synchronous, active high; clears all control state and drops
// any queued work. When the receiver holds rsp_ready low the output
// register holds its run, the walker stops, and once the queue fills the
// front end stops taking requests.
`default_nettype none

module nd_region_file_run_generator_unit #(
   parameter int MAX_RUNS    = nrfg_pkg::MAX_RUNS_DEFAULT,
   parameter int QUEUE_DEPTH = nrfg_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_object_rank,
   input  wire logic [1:0]                    req_region_rank,
   input  wire logic [nrfg_pkg::UNIT_W-1:0]   req_elem_bytes,
   input  wire logic [nrfg_pkg::DIM_W-1:0]    req_dim_mid,
   input  wire logic [nrfg_pkg::DIM_W-1:0]    req_dim_inner,
   input  wire logic [nrfg_pkg::DIM_W-1:0]    req_start_outer,
   input  wire logic [nrfg_pkg::DIM_W-1:0]    req_start_mid,
   input  wire logic [nrfg_pkg::DIM_W-1:0]    req_start_inner,
   input  wire logic [nrfg_pkg::DIM_W-1:0]    req_count_outer,
   input  wire logic [nrfg_pkg::DIM_W-1:0]    req_count_mid,
   input  wire logic [nrfg_pkg::DIM_W-1:0]    req_count_inner,
   input  wire logic                          req_write_dir,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [nrfg_pkg::BYTE_W-1:0]        rsp_byte_offset,
   output logic [nrfg_pkg::BYTE_W-1:0]        rsp_byte_length,
   output logic                               rsp_run_write,
   output logic [1:0]                         rsp_error_code,
   output logic                               rsp_last_run
);

   // Descriptor handoff: front end to queue, queue to run walker
   logic                   fq_valid, fq_ready;
   nrfg_pkg::run_desc_type fq_data;
   logic                   qb_valid, qb_ready;
   nrfg_pkg::run_desc_type qb_data;

   // Classify the request and work out base, length and strides
   nrfg_front #(
      .MAX_RUNS(MAX_RUNS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_object_rank (req_object_rank),
      .req_region_rank (req_region_rank),
      .req_elem_bytes  (req_elem_bytes),
      .req_dim_mid     (req_dim_mid),
      .req_dim_inner   (req_dim_inner),
      .req_start_outer (req_start_outer),
      .req_start_mid   (req_start_mid),
      .req_start_inner (req_start_inner),
      .req_count_outer (req_count_outer),
      .req_count_mid   (req_count_mid),
      .req_count_inner (req_count_inner),
      .req_write_dir   (req_write_dir),
      .push_valid      (fq_valid),
      .push_ready      (fq_ready),
      .push_data       (fq_data)
   );

   // Hold finished descriptors so setup and run emission stall independently
   nrfg_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   // Advance through the runs, one per cycle while the output register is free, into it
   nrfg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (qb_valid),
      .pop_ready       (qb_ready),
      .pop_data        (qb_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_byte_length (rsp_byte_length),
      .rsp_run_write   (rsp_run_write),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_run    (rsp_last_run)
   );

endmodule

`default_nettype wire

>>> tb/region_run_checker.sv
`default_nettype none

module region_run_checker
   import nrfg_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire logic [1:0]        req_object_rank,
   input  wire logic [1:0]        req_region_rank,
   input  wire logic [UNIT_W-1:0] req_elem_bytes,
   input  wire logic [DIM_W-1:0]  req_dim_mid,
   input  wire logic [DIM_W-1:0]  req_dim_inner,
   input  wire logic [DIM_W-1:0]  req_start_outer,
   input  wire logic [DIM_W-1:0]  req_start_mid,
   input  wire logic [DIM_W-1:0]  req_start_inner,
   input  wire logic [DIM_W-1:0]  req_count_outer,
   input  wire logic [DIM_W-1:0]  req_count_mid,
   input  wire logic [DIM_W-1:0]  req_count_inner,
   input  wire logic              req_write_dir,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic [BYTE_W-1:0] rsp_byte_offset,
   input  wire logic [BYTE_W-1:0] rsp_byte_length,
   input  wire logic              rsp_run_write,
   input  wire logic [1:0]        rsp_error_code,
   input  wire logic              rsp_last_run,
   output int unsigned            fail_count,
   output int unsigned            pending_runs,
   output int unsigned            results_checked
);

   localparam logic [BYTE_W-1:0] RUN_LIMIT = BYTE_W'(MAX_RUNS_DEFAULT);

   typedef struct packed {
      logic [BYTE_W-1:0] offset;
      logic [BYTE_W-1:0] length;
      logic              wr;
      err_type           err;
      logic              last;
   } run_type;

   run_type     expected_runs[$];
   int unsigned mismatches = 0;
   int unsigned checked = 0;

   assign fail_count      = mismatches;
   assign results_checked = checked;

   function automatic void push_run(input logic [BYTE_W-1:0] off, input logic [BYTE_W-1:0] len,
                                    input logic wr, input err_type err, input logic last);
      run_type r;
      r.offset = off;
      r.length = len;
      r.wr     = wr;
      r.err    = err;
      r.last   = last;
      expected_runs.push_back(r);
   endfunction

   // All arithmetic runs on 64-bit operands so that it wraps like the block.
   function automatic void predict_runs();
      logic [BYTE_W-1:0] unit, dm, di, so, sm, si, co, cm, ci, n_runs, i, j, k;
      logic              wr;
      unit = BYTE_W'(req_elem_bytes);
      dm   = BYTE_W'(req_dim_mid);
      di   = BYTE_W'(req_dim_inner);
      so   = BYTE_W'(req_start_outer);
      sm   = BYTE_W'(req_start_mid);
      si   = BYTE_W'(req_start_inner);
      co   = BYTE_W'(req_count_outer);
      cm   = BYTE_W'(req_count_mid);
      ci   = BYTE_W'(req_count_inner);
      wr   = req_write_dir;
      if (req_object_rank != req_region_rank) begin
         push_run('0, '0, wr, ERR_RANK_MISMATCH, 1'b1);
      end else if (req_region_rank == 2'd0) begin
         push_run('0, '0, wr, ERR_BAD_RANK, 1'b1);
      end else if (req_region_rank == 2'd1) begin
         push_run(so * unit, co * unit, wr, ERR_NONE, 1'b1);
      end else if (req_region_rank == 2'd2) begin
         if (sm == 0 && cm == dm) begin
            push_run(so * dm * unit, co * dm * unit, wr, ERR_NONE, 1'b1);
         end else if (co > RUN_LIMIT) begin
            push_run('0, '0, wr, ERR_TOO_MANY, 1'b1);
         end else if (co == 0) begin
            push_run('0, '0, wr, ERR_NONE, 1'b1);
         end else begin
            for (i = 0; i < co; i++)
               push_run(((so + i) * dm + sm) * unit, cm * unit, wr, ERR_NONE, i + 1 == co);
         end
      end else if (sm == 0 && cm == dm && si == 0 && ci == di) begin
         push_run(so * dm * di * unit, co * dm * di * unit, wr, ERR_NONE, 1'b1);
      end else if (si == 0 && ci == di) begin
         if (co > RUN_LIMIT) begin
            push_run('0, '0, wr, ERR_TOO_MANY, 1'b1);
         end else if (co == 0) begin
            push_run('0, '0, wr, ERR_NONE, 1'b1);
         end else begin
            for (i = 0; i < co; i++)
               push_run(((so + i) * dm * di + sm * di) * unit, cm * di * unit, wr, ERR_NONE,
                        i + 1 == co);
         end
      end else begin
         n_runs = co * cm;
         if (n_runs > RUN_LIMIT) begin
            push_run('0, '0, wr, ERR_TOO_MANY, 1'b1);
         end else if (n_runs == 0) begin
            push_run('0, '0, wr, ERR_NONE, 1'b1);
         end else begin
            k = 0;
            for (i = 0; i < co; i++) begin
               for (j = 0; j < cm; j++) begin
                  push_run(((so + i) * dm * di + (sm + j) * di + si) * unit, ci * unit, wr,
                           ERR_NONE, k + 1 == n_runs);
                  k++;
               end
            end
         end
      end
   endfunction

   // Compare each result before queuing new runs, so a request taken at
   // this edge can never answer a result taken at the same edge.
   always @(posedge clock) begin
      run_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (expected_runs.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected run: expected none, actual offset %h length %h",
                        $time, rsp_byte_offset, rsp_byte_length);
            end else begin
               want = expected_runs.pop_front();
               if (rsp_byte_offset !== want.offset) begin
                  mismatches++;
                  $display("%0t: byte_offset expected %h actual %h",
                           $time, want.offset, rsp_byte_offset);
               end
               if (rsp_byte_length !== want.length) begin
                  mismatches++;
                  $display("%0t: byte_length expected %h actual %h",
                           $time, want.length, rsp_byte_length);
               end
               if (rsp_run_write !== want.wr) begin
                  mismatches++;
                  $display("%0t: run_write expected %0b actual %0b",
                           $time, want.wr, rsp_run_write);
               end
               if (rsp_error_code !== want.err) begin
                  mismatches++;
                  $display("%0t: error_code expected %0d actual %0d",
                           $time, want.err, rsp_error_code);
               end
               if (rsp_last_run !== want.last) begin
                  mismatches++;
                  $display("%0t: last_run expected %0b actual %0b",
                           $time, want.last, rsp_last_run);
               end
            end
         end
         if (req_valid && req_ready)
            predict_runs();
      end
      pending_runs <= expected_runs.size();
   end

endmodule

`default_nettype wire

>>> tb/nd_region_file_run_generator_unit_tb.sv
`default_nettype none

module nd_region_file_run_generator_unit_tb;
   import nrfg_pkg::*;

   // Sequencing of the run.
   localparam int DIRECTED_COUNT = 25;
   localparam int RANDOM_COUNT   = 205;
   localparam int QUIET_TAIL     = 40;    // last random requests go out with no idling
   localparam int HOLD_AT        = 60;    // random request index that starts the long hold
   localparam int LONG_HOLD      = 300;   // cycles the receiver holds off for back-pressure
   localparam int DRAIN_CYCLES   = 40;    // wait after the last expected run, for strays
   localparam int IDLE_LIMIT     = 2000;  // cycles with no transfer before giving up

   localparam logic [DIM_W-1:0]  DIM_MAX  = '1;
   localparam logic [UNIT_W-1:0] UNIT_MAX = '1;

   typedef struct packed {
      logic [1:0]        object_rank;
      logic [1:0]        region_rank;
      logic [UNIT_W-1:0] elem_bytes;
      logic [DIM_W-1:0]  dim_mid;
      logic [DIM_W-1:0]  dim_inner;
      logic [DIM_W-1:0]  start_outer;
      logic [DIM_W-1:0]  start_mid;
      logic [DIM_W-1:0]  start_inner;
      logic [DIM_W-1:0]  count_outer;
      logic [DIM_W-1:0]  count_mid;
      logic [DIM_W-1:0]  count_inner;
      logic              write_dir;
   } region_req_type;

   // Every input starts at a known value before the first edge.
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_object_rank = '0;
   logic [1:0]        req_region_rank = '0;
   logic [UNIT_W-1:0] req_elem_bytes = '0;
   logic [DIM_W-1:0]  req_dim_mid = '0;
   logic [DIM_W-1:0]  req_dim_inner = '0;
   logic [DIM_W-1:0]  req_start_outer = '0;
   logic [DIM_W-1:0]  req_start_mid = '0;
   logic [DIM_W-1:0]  req_start_inner = '0;
   logic [DIM_W-1:0]  req_count_outer = '0;
   logic [DIM_W-1:0]  req_count_mid = '0;
   logic [DIM_W-1:0]  req_count_inner = '0;
   logic              req_write_dir = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [BYTE_W-1:0] rsp_byte_offset;
   logic [BYTE_W-1:0] rsp_byte_length;
   logic              rsp_run_write;
   logic [1:0]        rsp_error_code;
   logic              rsp_last_run;

   int unsigned fail_count;
   int unsigned pending_runs;
   int unsigned results_checked;
   int unsigned requests_sent = 0;
   int unsigned idle_cycles = 0;
   bit          quiet = 1'b0;          // set for the tail: no idling on either side
   bit          hold_done = 1'b0;      // receiver has done its one long hold

   always #5 clock = ~clock;

   nd_region_file_run_generator_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_object_rank(req_object_rank),
      .req_region_rank(req_region_rank),
      .req_elem_bytes(req_elem_bytes),
      .req_dim_mid(req_dim_mid),
      .req_dim_inner(req_dim_inner),
      .req_start_outer(req_start_outer),
      .req_start_mid(req_start_mid),
      .req_start_inner(req_start_inner),
      .req_count_outer(req_count_outer),
      .req_count_mid(req_count_mid),
      .req_count_inner(req_count_inner),
      .req_write_dir(req_write_dir),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_byte_offset(rsp_byte_offset),
      .rsp_byte_length(rsp_byte_length),
      .rsp_run_write(rsp_run_write),
      .rsp_error_code(rsp_error_code),
      .rsp_last_run(rsp_last_run)
   );

   region_run_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_object_rank(req_object_rank),
      .req_region_rank(req_region_rank),
      .req_elem_bytes(req_elem_bytes),
      .req_dim_mid(req_dim_mid),
      .req_dim_inner(req_dim_inner),
      .req_start_outer(req_start_outer),
      .req_start_mid(req_start_mid),
      .req_start_inner(req_start_inner),
      .req_count_outer(req_count_outer),
      .req_count_mid(req_count_mid),
      .req_count_inner(req_count_inner),
      .req_write_dir(req_write_dir),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_byte_offset(rsp_byte_offset),
      .rsp_byte_length(rsp_byte_length),
      .rsp_run_write(rsp_run_write),
      .rsp_error_code(rsp_error_code),
      .rsp_last_run(rsp_last_run),
      .fail_count(fail_count),
      .pending_runs(pending_runs),
      .results_checked(results_checked)
   );

   function automatic region_req_type make_request(
         input logic [1:0] orank, input logic [1:0] rrank, input logic [UNIT_W-1:0] eb,
         input logic [DIM_W-1:0] dm, input logic [DIM_W-1:0] di,
         input logic [DIM_W-1:0] so, input logic [DIM_W-1:0] sm, input logic [DIM_W-1:0] si,
         input logic [DIM_W-1:0] co, input logic [DIM_W-1:0] cm, input logic [DIM_W-1:0] ci,
         input logic wr);
      region_req_type r;
      r.object_rank = orank;
      r.region_rank = rrank;
      r.elem_bytes  = eb;
      r.dim_mid     = dm;
      r.dim_inner   = di;
      r.start_outer = so;
      r.start_mid   = sm;
      r.start_inner = si;
      r.count_outer = co;
      r.count_mid   = cm;
      r.count_inner = ci;
      r.write_dir   = wr;
      return r;
   endfunction

   // Mix full-width values (to toggle every bit) with small ones.
   function automatic logic [DIM_W-1:0] random_extent();
      case ($urandom_range(0, 2))
         0: return DIM_W'($urandom_range(0, 20'hFFFFF));
         1: return DIM_W'($urandom_range(0, 15));
         default: return DIM_W'($urandom_range(0, 1000));
      endcase
   endfunction

   // Loop counts: mostly a handful of runs, sometimes empty, the run limit, or past it.
   function automatic logic [DIM_W-1:0] loop_count();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return DIM_W'($urandom_range(MAX_RUNS_DEFAULT + 1, 20'hFFFFF));
         2: return DIM_W'(MAX_RUNS_DEFAULT);
         default: return DIM_W'($urandom_range(1, 8));
      endcase
   endfunction

   // Mostly well-formed requests of each layout, a few rank errors as noise.
   function automatic region_req_type random_request();
      region_req_type r;
      int unsigned pick;
      pick          = $urandom_range(0, 99);
      r.elem_bytes  = ($urandom_range(0, 7) == 0) ? UNIT_W'($urandom_range(0, 127))
                                                   : UNIT_W'($urandom_range(1, 64));
      r.dim_mid     = random_extent();
      r.dim_inner   = random_extent();
      r.start_outer = random_extent();
      r.start_mid   = random_extent();
      r.start_inner = random_extent();
      r.count_outer = random_extent();
      r.count_mid   = random_extent();
      r.count_inner = random_extent();
      r.write_dir   = 1'($urandom_range(0, 1));
      if (pick < 5) begin
         r.object_rank = 2'($urandom_range(0, 3));
         r.region_rank = r.object_rank + 2'($urandom_range(1, 3));
      end else if (pick < 8) begin
         r.object_rank = 2'd0;
         r.region_rank = 2'd0;
      end else if (pick < 20) begin
         r.object_rank = 2'd1;
         r.region_rank = 2'd1;
      end else if (pick < 32) begin
         r.object_rank = 2'd2;
         r.region_rank = 2'd2;
         r.start_mid   = '0;
         r.count_mid   = r.dim_mid;
      end else if (pick < 52) begin
         r.object_rank = 2'd2;
         r.region_rank = 2'd2;
         r.count_outer = loop_count();
      end else if (pick < 62) begin
         r.object_rank = 2'd3;
         r.region_rank = 2'd3;
         r.start_mid   = '0;
         r.count_mid   = r.dim_mid;
         r.start_inner = '0;
         r.count_inner = r.dim_inner;
      end else if (pick < 77) begin
         r.object_rank = 2'd3;
         r.region_rank = 2'd3;
         r.start_inner = '0;
         r.count_inner = r.dim_inner;
         r.count_outer = loop_count();
      end else begin
         r.object_rank = 2'd3;
         r.region_rank = 2'd3;
         r.count_outer = loop_count();
         r.count_mid   = loop_count();
      end
      return r;
   endfunction

   // Present one request and hold it until the transfer happens; an idle burst
   // may come first. Valid is lowered only on the idle path, so it never gets
   // two assignments in one step.
   task automatic offer_request(input region_req_type r);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_object_rank <= r.object_rank;
      req_region_rank <= r.region_rank;
      req_elem_bytes  <= r.elem_bytes;
      req_dim_mid     <= r.dim_mid;
      req_dim_inner   <= r.dim_inner;
      req_start_outer <= r.start_outer;
      req_start_mid   <= r.start_mid;
      req_start_inner <= r.start_inner;
      req_count_outer <= r.count_outer;
      req_count_mid   <= r.count_mid;
      req_count_inner <= r.count_inner;
      req_write_dir   <= r.write_dir;
      req_valid       <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
   endtask

   // Request side: directed corners, then random traffic, then drain and verdict.
   initial begin
      region_req_type directed[$];
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Rank errors: two mismatches, then both ranks zero.
      directed.push_back(make_request(2'd1, 2'd2, 7'd4, 20'd5, 20'd5, 20'd1, 20'd1, 20'd1,
                                      20'd1, 20'd1, 20'd1, 1'b1));
      directed.push_back(make_request(2'd3, 2'd0, UNIT_MAX, DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX,
                                      DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX, 1'b0));
      directed.push_back(make_request(2'd0, 2'd0, 7'd8, 20'd3, 20'd3, 20'd0, 20'd0, 20'd0,
                                      20'd2, 20'd2, 20'd2, 1'b1));
      // Rank 1: largest fields, zero element size, widest element size with no elements.
      directed.push_back(make_request(2'd1, 2'd1, 7'd64, '0, '0, DIM_MAX, '0, '0,
                                      DIM_MAX, '0, '0, 1'b1));
      directed.push_back(make_request(2'd1, 2'd1, 7'd0, 20'd9, 20'd9, 20'd5, 20'd2, 20'd2,
                                      20'd7, 20'd3, 20'd3, 1'b0));
      directed.push_back(make_request(2'd1, 2'd1, UNIT_MAX, 20'd1, 20'd1, '0, '0, '0,
                                      '0, '0, '0, 1'b0));
      // Rank 2: whole rows merge, also to a zero-length run.
      directed.push_back(make_request(2'd2, 2'd2, 7'd64, DIM_MAX, '0, DIM_MAX, '0, '0,
                                      DIM_MAX, DIM_MAX, '0, 1'b1));
      directed.push_back(make_request(2'd2, 2'd2, 7'd4, '0, 20'd6, 20'd2, '0, 20'd3,
                                      20'd3, '0, 20'd1, 1'b0));
      // Rank 2 loop: at the run limit, one past it, empty, one run at full width.
      directed.push_back(make_request(2'd2, 2'd2, 7'd2, 20'd1000, '0, 20'd7, 20'd3, '0,
                                      20'd64, 20'd10, '0, 1'b1));
      directed.push_back(make_request(2'd2, 2'd2, 7'd2, 20'd1000, '0, 20'd7, 20'd3, '0,
                                      20'd65, 20'd10, '0, 1'b0));
      directed.push_back(make_request(2'd2, 2'd2, 7'd8, 20'd50, '0, 20'd7, 20'd1, '0,
                                      '0, 20'd10, '0, 1'b1));
      directed.push_back(make_request(2'd2, 2'd2, UNIT_MAX, DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX,
                                      DIM_MAX, 20'd1, DIM_MAX, DIM_MAX, 1'b1));
      // Rank 3: whole planes merge; the largest offset wraps past 64 bits.
      directed.push_back(make_request(2'd3, 2'd3, UNIT_MAX, DIM_MAX, DIM_MAX, DIM_MAX, '0, '0,
                                      DIM_MAX, DIM_MAX, DIM_MAX, 1'b0));
      directed.push_back(make_request(2'd3, 2'd3, 7'd4, 20'd6, 20'd9, 20'd4, '0, '0,
                                      '0, 20'd6, 20'd9, 1'b1));
      // Rank 3, whole rows: a few planes, the limit, one past it, empty.
      directed.push_back(make_request(2'd3, 2'd3, 7'd4, 20'd30, 20'd50, 20'd1, 20'd2, '0,
                                      20'd4, 20'd5, 20'd50, 1'b0));
      directed.push_back(make_request(2'd3, 2'd3, 7'd1, 20'd30, 20'd50, 20'd1, 20'd2, '0,
                                      20'd64, 20'd5, 20'd50, 1'b1));
      directed.push_back(make_request(2'd3, 2'd3, 7'd1, 20'd30, 20'd50, 20'd1, 20'd2, '0,
                                      20'd65, 20'd5, 20'd50, 1'b0));
      directed.push_back(make_request(2'd3, 2'd3, 7'd1, 20'd30, 20'd50, 20'd1, 20'd2, '0,
                                      '0, 20'd5, 20'd50, 1'b1));
      // Rank 3 grid: the limit, one past it, empty either way, widest, zero element size.
      directed.push_back(make_request(2'd3, 2'd3, 7'd2, 20'd20, 20'd40, 20'd3, 20'd4, 20'd5,
                                      20'd8, 20'd8, 20'd6, 1'b0));
      directed.push_back(make_request(2'd3, 2'd3, 7'd2, 20'd20, 20'd40, 20'd3, 20'd4, 20'd5,
                                      20'd5, 20'd13, 20'd6, 1'b1));
      directed.push_back(make_request(2'd3, 2'd3, 7'd2, 20'd20, 20'd40, 20'd3, 20'd4, 20'd5,
                                      '0, 20'd5, 20'd6, 1'b0));
      directed.push_back(make_request(2'd3, 2'd3, 7'd2, 20'd20, 20'd40, 20'd3, 20'd4, 20'd5,
                                      20'd3, '0, 20'd6, 1'b1));
      directed.push_back(make_request(2'd3, 2'd3, UNIT_MAX, DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX,
                                      DIM_MAX, 20'd1, 20'd1, DIM_MAX, 1'b1));
      directed.push_back(make_request(2'd3, 2'd3, 7'd0, 20'd9, 20'd7, 20'd2, 20'd1, DIM_MAX,
                                      20'd2, 20'd3, DIM_MAX, 1'b0));
      directed.push_back(make_request(2'd3, 2'd3, 7'd4, 20'd9, 20'd7, 20'd2, 20'd1, 20'd1,
                                      DIM_MAX, DIM_MAX, 20'd2, 1'b1));

      foreach (directed[n])
         offer_request(directed[n]);

      for (int n = 0; n < RANDOM_COUNT; n++) begin
         if (n == RANDOM_COUNT - QUIET_TAIL)
            quiet = 1'b1;
         offer_request(random_request());
      end
      req_valid <= 1'b0;
      // Let the checker count the runs of the last transfer before polling.
      @(posedge clock);

      // Drain: wait for every expected run, then DRAIN_CYCLES more for strays.
      while (pending_runs != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d requests (%0d directed corners, rest random across ranks, errors,",
               requests_sent, DIRECTED_COUNT);
      $display("summary: merged and looped layouts), %0d results checked with stalls on both sides",
               results_checked);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Result side: random stall bursts, ready stretches, and one long hold,
   // started once the sender is well into the random traffic, that backs the
   // block up into its request port while the sender keeps offering.
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && !quiet && int'(requests_sent) >= DIRECTED_COUNT + HOLD_AT) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Watchdog: end the run if no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

endmodule

`default_nettype wire
